// File: hw/rtl/ira_pkg.sv
package ira_pkg;

  localparam int unsigned RadixWidth = 6;
  localparam int unsigned CharWidth  = 7;

  localparam logic [RadixWidth-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RadixWidth-1:0] RADIX_MAX    = 6'd36;
  localparam logic [RadixWidth-1:0] SIGNED_RADIX = 6'd10;

  localparam logic [CharWidth-1:0] MINUS_CODE = 7'h2D;
  localparam logic [CharWidth-1:0] ZERO_CODE  = 7'h30;
  localparam logic [CharWidth-1:0] ALPHA_CODE = 7'h61;
  localparam logic [CharWidth-1:0] ERROR_CODE = 7'h00;

  // Handshake status of the shared divider toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  // Map a digit value (0 to 35) onto '0'-'9', 'a'-'z'.
  function automatic logic [CharWidth-1:0] digit_char(input logic [RadixWidth-1:0] d);
    logic [CharWidth-1:0] d_ext;
    d_ext = {1'b0, d};
    if (d < 6'd10) begin
      return ZERO_CODE + d_ext;
    end
    return ALPHA_CODE + d_ext - 7'd10;
  endfunction

endpackage

// File: hw/rtl/ira_divider.sv
module ira_divider #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [VALUE_WIDTH-1:0]               dividend_i,
  input  logic [ira_pkg::RadixWidth-1:0]       divisor_i,
  output ira_pkg::div_status_t                 status_o,
  output logic [VALUE_WIDTH-1:0]               quotient_o,
  output logic [ira_pkg::RadixWidth-1:0]       remainder_o
);

  localparam int unsigned CntWidth = $clog2(VALUE_WIDTH);
  localparam int unsigned RW       = ira_pkg::RadixWidth;

  logic [VALUE_WIDTH-1:0] quo_q, quo_d;
  logic [RW-1:0]          rem_q, rem_d;
  logic [RW-1:0]          dvs_q, dvs_d;
  logic [CntWidth-1:0]    cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [RW:0]            trial;
  logic [RW:0]            diff;
  logic                   fits;

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  assign trial = {rem_q, quo_q[VALUE_WIDTH-1]};
  assign fits  = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      quo_d = {quo_q[VALUE_WIDTH-2:0], fits};
      rem_d = fits ? diff[RW-1:0] : trial[RW-1:0];
      cnt_d = cnt_q + CntWidth'(1);
      if (cnt_q == CntWidth'(VALUE_WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

// File: hw/rtl/integer_to_radix_ascii_unit.sv
// Integer to radix ASCII converter. Each input beat carries a signed value
// (low VALUE_WIDTH bits used, two's complement) and a base; the block answers
// with one output beat per character, most significant digit first, digits
// above nine as 'a'-'z', tlast on the final character. A '-' leads only for
// negative values in base 10; other bases print the magnitude unsigned. Zero
// prints "0". A base outside 2..36 gives a single beat with code 0, tuser set
// and tlast set. One conversion at a time: tready stays low from acceptance
// until the last character is loaded into the output register. Each digit
// comes from the shared one-bit-per-cycle restoring divider; the digits
// are pushed onto a stack as they appear, then each is read back from the
// stack and loaded into the output register, waiting while that register
// is full. A leading sign is emitted before the read-back starts.
module integer_to_radix_ascii_unit #(
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [63:0] value, [69:64] radix, [71:70] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [6:0] char_code, [7] zero
  output logic        m_axis_tlast_o,
  output logic        m_axis_tuser_o    // [0] base_error
);

  localparam int unsigned RW = ira_pkg::RadixWidth;
  localparam int unsigned CW = ira_pkg::CharWidth;
  localparam int unsigned AW = $clog2(VALUE_WIDTH);
  localparam int unsigned NW = $clog2(VALUE_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_READ,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  // Digit count; doubles as stack pointer for the read-back.
  logic [NW-1:0] nd_q, nd_d;
  logic          sign_q, sign_d;

  // Output register.
  logic          m_valid_q, m_valid_d;
  logic [CW-1:0] m_char_q, m_char_d;
  logic          m_last_q, m_last_d;
  logic          m_err_q, m_err_d;

  logic                   out_free;
  logic                   in_fire;
  logic [VALUE_WIDTH-1:0] in_value;
  logic [RW-1:0]          in_radix;
  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic                   radix_ok;

  logic                   div_start;
  logic [VALUE_WIDTH-1:0] div_dividend;
  ira_pkg::div_status_t   div_status;
  logic [VALUE_WIDTH-1:0] div_quotient;
  logic [RW-1:0]          div_remainder;
  logic                   quot_zero;
  logic [RW-1:0]          div_radix_q;

  // Digit stack, LSD written first, read back from the top.
  logic [RW-1:0] digit_mem [VALUE_WIDTH];
  logic [RW-1:0] rd_data_q;
  logic          mem_we;
  logic          rd_en;
  logic [NW-1:0] top_idx;

  assign in_value = s_axis_tdata_i[VALUE_WIDTH-1:0];
  assign in_radix = s_axis_tdata_i[64 +: RW];
  assign in_neg   = in_value[VALUE_WIDTH-1];
  // Negation in VALUE_WIDTH bits maps the most negative value onto 2^(W-1) unsigned.
  assign in_mag   = in_neg ? ({VALUE_WIDTH{1'b0}} - in_value) : in_value;
  assign radix_ok = (in_radix >= ira_pkg::RADIX_MIN) && (in_radix <= ira_pkg::RADIX_MAX);

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  assign quot_zero = (div_quotient == '0);

  // Start on a fresh beat, or chain the next division off the last quotient.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = in_mag;
    if (in_fire && radix_ok) begin
      div_start = 1'b1;
    end else if ((state_q == ST_DIVIDE) && div_status.done && !quot_zero) begin
      div_start    = 1'b1;
      div_dividend = div_quotient;
    end
  end

  ira_divider #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (in_fire ? in_radix : div_radix_q),
    .status_o    (div_status),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

  // Hold the base for chained divisions.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      div_radix_q <= in_radix;
    end
  end

  assign mem_we  = (state_q == ST_DIVIDE) && div_status.done;
  assign rd_en   = (state_q == ST_READ);
  assign top_idx = nd_q - NW'(1);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      digit_mem[nd_q[AW-1:0]] <= div_remainder;
    end
    if (rd_en) begin
      rd_data_q <= digit_mem[top_idx[AW-1:0]];
    end
  end

  always_comb begin
    state_d   = state_q;
    nd_d      = nd_q;
    sign_d    = sign_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_char_d  = m_char_q;
    m_last_d  = m_last_q;
    m_err_d   = m_err_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!radix_ok) begin
            m_valid_d = 1'b1;
            m_char_d  = ira_pkg::ERROR_CODE;
            m_last_d  = 1'b1;
            m_err_d   = 1'b1;
          end else begin
            nd_d    = '0;
            sign_d  = in_neg && (in_radix == ira_pkg::SIGNED_RADIX);
            state_d = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (div_status.done) begin
          nd_d = nd_q + NW'(1);
          if (quot_zero) begin
            state_d = sign_q ? ST_SIGN : ST_READ;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = ira_pkg::MINUS_CODE;
          m_last_d  = 1'b0;
          m_err_d   = 1'b0;
          state_d   = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_char_d  = ira_pkg::digit_char(rd_data_q);
          m_last_d  = (nd_q == NW'(1));
          m_err_d   = 1'b0;
          nd_d      = top_idx;
          state_d   = (nd_q == NW'(1)) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      nd_q      <= '0;
      sign_q    <= 1'b0;
      m_valid_q <= 1'b0;
      m_char_q  <= '0;
      m_last_q  <= 1'b0;
      m_err_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      nd_q      <= nd_d;
      sign_q    <= sign_d;
      m_valid_q <= m_valid_d;
      m_char_q  <= m_char_d;
      m_last_q  <= m_last_d;
      m_err_q   <= m_err_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_char_q};
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_err_q;

  // An error beat is always a lone, final beat with code 0.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o && (m_char_q == ira_pkg::ERROR_CODE))
    else $error("error beat without tlast or with nonzero code");

  // Never restart the divider while it is mid-division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_status.busy)
    else $error("divider restarted while busy");

  // The digit stack is never read back empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) || (state_q == ST_EMIT) |-> nd_q != '0)
    else $error("digit stack underflow");

  // The digit count cannot outgrow the stack.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> nd_q < NW'(VALUE_WIDTH))
    else $error("digit stack overflow");

endmodule
